// ===== rtl/nlrp_pkg.sv =====
`timescale 1ns / 1ps

package nlrp_pkg;

  // Default longest name string accepted in a tuple.
  localparam int unsigned NameMaxDefault = 31;

  // Entries in the queue between the parser and the output side.
  localparam int unsigned QueueDepth = 2;

  // High nibble of the function byte that marks a lookup reply.
  localparam logic [3:0] FuncLookupReply = 4'd3;

  // Largest entity count; the count saturates here.
  localparam logic [7:0] EntityCountMax = 8'hFF;

  // Register indexes on the configuration port (byte address 4 * index).
  localparam logic [1:0] RegExpectedProtocol = 2'd0;
  localparam logic [1:0] RegExpectedId       = 2'd1;
  localparam logic [1:0] RegMaxEntities      = 2'd2;

  localparam logic [7:0] ExpectedProtocolReset = 8'd2;
  localparam logic [7:0] ExpectedIdReset       = 8'd0;
  localparam logic [7:0] MaxEntitiesReset      = 8'd255;

  typedef enum logic [2:0] {
    KIND_OBJECT  = 3'd0,
    KIND_TYPE    = 3'd1,
    KIND_ZONE    = 3'd2,
    KIND_DONE    = 3'd3,
    KIND_DISCARD = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    HDR_PROTOCOL = 2'd0,
    HDR_FUNCTION = 2'd1,
    HDR_ID       = 2'd2,
    HDR_BODY     = 2'd3
  } hdr_e;

  typedef enum logic [3:0] {
    FS_NET_HI    = 4'd0,
    FS_NET_LO    = 4'd1,
    FS_NODE      = 4'd2,
    FS_SOCKET    = 4'd3,
    FS_ENUM      = 4'd4,
    FS_OBJ_LEN   = 4'd5,
    FS_OBJ_CHAR  = 4'd6,
    FS_TYPE_LEN  = 4'd7,
    FS_TYPE_CHAR = 4'd8,
    FS_ZONE_LEN  = 4'd9,
    FS_ZONE_CHAR = 4'd10
  } field_e;

  typedef struct packed {
    logic [7:0] expected_protocol;
    logic [7:0] expected_id;
    logic [7:0] max_entities;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  char_value;
    logic [4:0]  char_index;
    logic [15:0] network;
    logic [7:0]  node;
    logic [7:0]  socket_number;
    logic [7:0]  entity_number;
    logic        discard;
  } result_t;

endpackage

// ===== rtl/nlrp_parser.sv =====
`timescale 1ns / 1ps

module nlrp_parser #(
  parameter int unsigned NameMax = nlrp_pkg::NameMaxDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              byte_fire_i,
  input  logic              command_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  input  nlrp_pkg::cfg_t    cfg_i,
  output logic              res_valid_o,
  output nlrp_pkg::result_t res_o
);

  localparam int unsigned LenW = $clog2(NameMax + 1);
  localparam logic [7:0] NameLimit = 8'(NameMax);

  nlrp_pkg::hdr_e   hdr_q, hdr_d;
  nlrp_pkg::field_e fs_q, fs_d;
  logic             acc_q, acc_d;
  logic             stop_q, stop_d;
  logic [3:0]       tuples_q, tuples_d;
  logic [LenW-1:0]  str_left_q, str_left_d;
  logic [LenW-1:0]  char_pos_q, char_pos_d;
  logic [15:0]      net_q, net_d;
  logic [7:0]       node_q, node_d;
  logic [7:0]       sock_q, sock_d;
  logic [7:0]       ent_q, ent_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q      <= nlrp_pkg::HDR_PROTOCOL;
      fs_q       <= nlrp_pkg::FS_NET_HI;
      acc_q      <= 1'b0;
      stop_q     <= 1'b0;
      tuples_q   <= '0;
      str_left_q <= '0;
      char_pos_q <= '0;
      net_q      <= '0;
      node_q     <= '0;
      sock_q     <= '0;
      ent_q      <= '0;
    end else begin
      hdr_q      <= hdr_d;
      fs_q       <= fs_d;
      acc_q      <= acc_d;
      stop_q     <= stop_d;
      tuples_q   <= tuples_d;
      str_left_q <= str_left_d;
      char_pos_q <= char_pos_d;
      net_q      <= net_d;
      node_q     <= node_d;
      sock_q     <= sock_d;
      ent_q      <= ent_d;
    end
  end

  always_comb begin
    logic clear_tuple;
    logic finish;
    hdr_d       = hdr_q;
    fs_d        = fs_q;
    acc_d       = acc_q;
    stop_d      = stop_q;
    tuples_d    = tuples_q;
    str_left_d  = str_left_q;
    char_pos_d  = char_pos_q;
    net_d       = net_q;
    node_d      = node_q;
    sock_d      = sock_q;
    ent_d       = ent_q;
    clear_tuple = 1'b0;
    finish      = 1'b0;
    res_valid_o = 1'b0;
    res_o.kind          = nlrp_pkg::KIND_OBJECT;
    res_o.char_value    = data_byte_i;
    res_o.char_index    = 5'(char_pos_q);
    res_o.network       = net_q;
    res_o.node          = node_q;
    res_o.socket_number = sock_q;
    res_o.entity_number = ent_q;
    res_o.discard       = 1'b0;

    if (byte_fire_i && command_i) begin
      hdr_d       = nlrp_pkg::HDR_PROTOCOL;
      acc_d       = 1'b0;
      stop_d      = 1'b0;
      tuples_d    = '0;
      ent_d       = '0;
      clear_tuple = 1'b1;
    end else if (byte_fire_i) begin
      if (!stop_q && !acc_q) begin
        unique case (hdr_q)
          nlrp_pkg::HDR_PROTOCOL: begin
            if (data_byte_i != cfg_i.expected_protocol || ent_q >= cfg_i.max_entities) begin
              stop_d = 1'b1;
            end else begin
              hdr_d = nlrp_pkg::HDR_FUNCTION;
            end
          end
          nlrp_pkg::HDR_FUNCTION: begin
            if (data_byte_i[7:4] != nlrp_pkg::FuncLookupReply) begin
              stop_d = 1'b1;
            end else begin
              tuples_d = data_byte_i[3:0];
              hdr_d    = nlrp_pkg::HDR_ID;
            end
          end
          default: begin
            if (data_byte_i != cfg_i.expected_id) begin
              stop_d = 1'b1;
            end else begin
              acc_d = 1'b1;
              hdr_d = nlrp_pkg::HDR_BODY;
            end
          end
        endcase
      end else if (!stop_q) begin
        if (fs_q == nlrp_pkg::FS_NET_HI &&
            (tuples_q == '0 || ent_q >= cfg_i.max_entities)) begin
          stop_d = 1'b1;
        end else begin
          unique case (fs_q) inside
            nlrp_pkg::FS_NET_HI: begin
              net_d = {data_byte_i, 8'h00};
              fs_d  = nlrp_pkg::FS_NET_LO;
            end
            nlrp_pkg::FS_NET_LO: begin
              net_d = {net_q[15:8], data_byte_i};
              fs_d  = nlrp_pkg::FS_NODE;
            end
            nlrp_pkg::FS_NODE: begin
              node_d = data_byte_i;
              fs_d   = nlrp_pkg::FS_SOCKET;
            end
            nlrp_pkg::FS_SOCKET: begin
              sock_d = data_byte_i;
              fs_d   = nlrp_pkg::FS_ENUM;
            end
            nlrp_pkg::FS_ENUM: begin
              fs_d = nlrp_pkg::FS_OBJ_LEN;
            end
            nlrp_pkg::FS_OBJ_LEN, nlrp_pkg::FS_TYPE_LEN, nlrp_pkg::FS_ZONE_LEN: begin
              if (data_byte_i > NameLimit) begin
                res_valid_o      = 1'b1;
                res_o.kind       = nlrp_pkg::KIND_DISCARD;
                res_o.char_value = '0;
                res_o.char_index = '0;
                res_o.discard    = 1'b1;
                stop_d           = 1'b1;
                clear_tuple      = 1'b1;
              end else begin
                str_left_d = LenW'(data_byte_i);
                char_pos_d = '0;
                if (data_byte_i == '0) begin
                  if (fs_q == nlrp_pkg::FS_ZONE_LEN) begin
                    res_valid_o      = 1'b1;
                    res_o.kind       = nlrp_pkg::KIND_DONE;
                    res_o.char_value = '0;
                    res_o.char_index = '0;
                    finish           = 1'b1;
                  end else begin
                    fs_d = nlrp_pkg::field_e'(fs_q + 4'd2);
                  end
                end else begin
                  fs_d = nlrp_pkg::field_e'(fs_q + 4'd1);
                end
              end
            end
            nlrp_pkg::FS_OBJ_CHAR, nlrp_pkg::FS_TYPE_CHAR, nlrp_pkg::FS_ZONE_CHAR: begin
              res_valid_o = 1'b1;
              char_pos_d  = char_pos_q + LenW'(1);
              str_left_d  = str_left_q - LenW'(1);
              if (fs_q == nlrp_pkg::FS_OBJ_CHAR) begin
                res_o.kind = nlrp_pkg::KIND_OBJECT;
              end else if (fs_q == nlrp_pkg::FS_TYPE_CHAR) begin
                res_o.kind = nlrp_pkg::KIND_TYPE;
              end else begin
                res_o.kind = nlrp_pkg::KIND_ZONE;
              end
              if (str_left_q == LenW'(1)) begin
                if (fs_q == nlrp_pkg::FS_ZONE_CHAR) begin
                  res_o.kind       = nlrp_pkg::KIND_DONE;
                  res_o.char_index = 5'(char_pos_d);
                  finish           = 1'b1;
                end else begin
                  fs_d = nlrp_pkg::field_e'(fs_q + 4'd1);
                end
              end
            end
            default: begin
              stop_d      = 1'b1;
              clear_tuple = 1'b1;
            end
          endcase
        end
      end

      if (finish) begin
        if (ent_q < nlrp_pkg::EntityCountMax) begin
          ent_d = ent_q + 8'd1;
        end
        if (tuples_q != '0) begin
          tuples_d = tuples_q - 4'd1;
        end
        clear_tuple = 1'b1;
      end

      // The last byte of a packet ends it; a tuple still open is reported as discarded,
      // showing whatever address fields it had gathered so far.
      if (last_byte_i) begin
        if (acc_d && !stop_d && !clear_tuple && fs_d != nlrp_pkg::FS_NET_HI) begin
          res_valid_o      = 1'b1;
          res_o.kind       = nlrp_pkg::KIND_DISCARD;
          res_o.char_value = '0;
          res_o.char_index = '0;
          res_o.network    = net_d;
          res_o.node       = node_d;
          res_o.socket_number = sock_d;
          res_o.discard    = 1'b1;
        end
        hdr_d       = nlrp_pkg::HDR_PROTOCOL;
        acc_d       = 1'b0;
        stop_d      = 1'b0;
        tuples_d    = '0;
        clear_tuple = 1'b1;
      end
    end

    if (clear_tuple) begin
      fs_d       = nlrp_pkg::FS_NET_HI;
      str_left_d = '0;
      char_pos_d = '0;
      net_d      = '0;
      node_d     = '0;
      sock_d     = '0;
    end
  end

endmodule

// ===== rtl/nlrp_fifo.sv =====
`timescale 1ns / 1ps

module nlrp_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = nlrp_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             pop;

  assign full_o      = (count_q == CntW'(Depth));
  assign pop_valid_o = (count_q != '0);
  assign pop         = pop_valid_o && pop_ready_i;
  assign pop_data_o  = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] ptr);
    return (ptr == PtrW'(Depth - 1)) ? '0 : ptr + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/nbp_lookup_reply_parser.sv =====
`timescale 1ns / 1ps

// Lookup-reply parser for the name-binding protocol.
// The input channel carries one payload byte per transfer, with last_byte_i marking the
// final byte of a packet; command_i set instead starts a new lookup, clearing the parser
// and the entity count without producing a result. The parser checks the three-byte
// header against the configured protocol and request id and then walks each tuple,
// emitting one result transfer per name character and one per discarded entity; the final
// zone character, or an empty zone length, is reported as the entity's completion. Bytes
// that produce no result simply update the parser. Throughput is one byte per cycle while
// the result queue has room: each byte is handled by a single pass through the field-step
// logic of the front parser. Each result is written into a two-entry queue when its byte
// is accepted and leaves from the queue head, so the parser keeps taking bytes while a
// result waits; when a receiver stall fills the queue, in_ready_o drops until one drains.
// Configuration registers sit on the APB port at byte addresses 0 (expected protocol),
// 4 (expected id) and 8 (entity limit); write them only while no byte is in flight.
// Reset returns the registers to their defaults, empties the queue and clears the parser.
module nbp_lookup_reply_parser #(
  parameter int unsigned NameMax = nlrp_pkg::NameMaxDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  char_value_o,
  output logic [4:0]  char_index_o,
  output logic [15:0] network_o,
  output logic [7:0]  node_o,
  output logic [7:0]  socket_number_o,
  output logic [7:0]  entity_number_o,
  output logic        discard_o
);

  localparam int unsigned ResW = $bits(nlrp_pkg::result_t);

  nlrp_pkg::cfg_t    cfg_q;
  nlrp_pkg::result_t res, head;
  logic              res_valid;
  logic              queue_full;
  logic              byte_fire;
  logic [1:0]        reg_index;
  logic [ResW-1:0]   head_bits;

  // Configuration registers.
  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_protocol <= nlrp_pkg::ExpectedProtocolReset;
      cfg_q.expected_id       <= nlrp_pkg::ExpectedIdReset;
      cfg_q.max_entities      <= nlrp_pkg::MaxEntitiesReset;
    end else if (psel && penable && pwrite) begin
      unique case (reg_index)
        nlrp_pkg::RegExpectedProtocol: cfg_q.expected_protocol <= pwdata[7:0];
        nlrp_pkg::RegExpectedId:       cfg_q.expected_id       <= pwdata[7:0];
        nlrp_pkg::RegMaxEntities:      cfg_q.max_entities      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      nlrp_pkg::RegExpectedProtocol: prdata = {24'h0, cfg_q.expected_protocol};
      nlrp_pkg::RegExpectedId:       prdata = {24'h0, cfg_q.expected_id};
      nlrp_pkg::RegMaxEntities:      prdata = {24'h0, cfg_q.max_entities};
      default:                       prdata = '0;
    endcase
  end

  // Front: the byte parser. It takes a byte whenever the queue has room.
  assign in_ready_o = !queue_full;
  assign byte_fire  = in_valid_i && in_ready_o;

  nlrp_parser #(
    .NameMax(NameMax)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_fire_i (byte_fire),
    .command_i   (command_i),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Back: the result queue, whose head drives the output channel.
  nlrp_fifo #(
    .Width(ResW),
    .Depth(nlrp_pkg::QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (queue_full),
    .pop_valid_o (out_valid_o),
    .pop_ready_i (out_ready_i),
    .pop_data_o  (head_bits)
  );

  assign head            = nlrp_pkg::result_t'(head_bits);
  assign kind_o          = head.kind;
  assign char_value_o    = head.char_value;
  assign char_index_o    = head.char_index;
  assign network_o       = head.network;
  assign node_o          = head.node;
  assign socket_number_o = head.socket_number;
  assign entity_number_o = head.entity_number;
  assign discard_o       = head.discard;

endmodule

// ===== tb/sv/tb_nbp_lookup_reply_parser.sv =====
`timescale 1ns / 1ps

// Testbench for the lookup-reply parser.
module tb_nbp_lookup_reply_parser;
  import nlrp_pkg::*;

  // The block is built with its default name limit, so the parser model uses the same value.
  localparam int NameMax = NameMaxDefault;
  // Cycles with no transfer at all before the run is declared hung. The slowest correct
  // stretch is a receiver stall plus a sender gap plus a register write.
  localparam int WatchLimit = 2000;
  // Results are registered only in the two-entry queue, so settling after the last expected
  // result covers any work still inside the block.
  localparam int SettleCycles = 4;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        command_i;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  kind_o;
  logic [7:0]  char_value_o;
  logic [4:0]  char_index_o;
  logic [15:0] network_o;
  logic [7:0]  node_o;
  logic [7:0]  socket_number_o;
  logic [7:0]  entity_number_o;
  logic        discard_o;

  nbp_lookup_reply_parser uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .char_value_o    (char_value_o),
    .char_index_o    (char_index_o),
    .network_o       (network_o),
    .node_o          (node_o),
    .socket_number_o (socket_number_o),
    .entity_number_o (entity_number_o),
    .discard_o       (discard_o)
  );

  // 20 ns clock period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Parser model. It keeps its own copy of the registers and of the parse state and is
  // advanced once per accepted input transfer.
  // ---------------------------------------------------------------------------------------
  cfg_t        cfg;
  hdr_e        hdr_pos;
  logic        pkt_ok;
  logic        pkt_stop;
  logic [3:0]  tuples_left;
  field_e      step;
  logic [4:0]  str_left;
  logic [4:0]  chr_pos;
  logic [15:0] net_q;
  logic [7:0]  node_q;
  logic [7:0]  sock_q;
  logic [7:0]  ent_cnt;

  // Results still owed by the block, oldest first.
  result_t pending_results[$];
  // Bytes of the reply being assembled for sending.
  logic [7:0] pkt_q[$];

  int  fail_count;
  int  sent_items;
  bit  send_idle;
  bit  recv_idle;
  bit  quiet;
  int  recv_stall;
  int  stuck_cycles;

  function automatic void clear_tuple();
    step     = FS_NET_HI;
    str_left = '0;
    chr_pos  = '0;
    net_q    = '0;
    node_q   = '0;
    sock_q   = '0;
  endfunction

  function automatic void clear_packet();
    hdr_pos     = HDR_PROTOCOL;
    pkt_ok      = 1'b0;
    pkt_stop    = 1'b0;
    tuples_left = '0;
    clear_tuple();
  endfunction

  // Every result carries the address captured so far and the entity's table position.
  function automatic result_t make_result(kind_e k, logic [7:0] ch, logic [4:0] idx);
    result_t r;
    r.kind          = k;
    r.char_value    = ch;
    r.char_index    = idx;
    r.network       = net_q;
    r.node          = node_q;
    r.socket_number = sock_q;
    r.entity_number = ent_cnt;
    r.discard       = (k == KIND_DISCARD);
    return r;
  endfunction

  function automatic result_t complete_entity(logic [7:0] ch, logic [4:0] len);
    result_t r;
    r = make_result(KIND_DONE, ch, len);
    if (ent_cnt != EntityCountMax) ent_cnt = ent_cnt + 8'd1;
    if (tuples_left != 0) tuples_left = tuples_left - 4'd1;
    clear_tuple();
    return r;
  endfunction

  // One byte inside the tuple area of an accepted packet.
  function automatic bit tuple_byte(logic [7:0] b, output result_t r);
    bit      hit;
    kind_e   k;
    logic [4:0] idx;
    hit = 1'b0;
    r   = '0;
    // A new tuple may only begin while the count allows it and the limit is not reached.
    if (step == FS_NET_HI && (tuples_left == 0 || ent_cnt >= cfg.max_entities)) begin
      pkt_stop = 1'b1;
      return 1'b0;
    end
    case (step)
      FS_NET_HI: begin
        net_q = {b, 8'h00};
        step  = FS_NET_LO;
      end
      FS_NET_LO: begin
        net_q[7:0] = b;
        step       = FS_NODE;
      end
      FS_NODE: begin
        node_q = b;
        step   = FS_SOCKET;
      end
      FS_SOCKET: begin
        sock_q = b;
        step   = FS_ENUM;
      end
      FS_ENUM: step = FS_OBJ_LEN;
      FS_OBJ_LEN, FS_TYPE_LEN, FS_ZONE_LEN: begin
        if (b > NameMax) begin
          // A name that is too long throws the entity away and the rest of the packet.
          r        = make_result(KIND_DISCARD, 8'd0, 5'd0);
          pkt_stop = 1'b1;
          clear_tuple();
          hit      = 1'b1;
        end else begin
          str_left = 5'(b);
          chr_pos  = '0;
          if (b == 0) begin
            // An empty zone name completes the entity on its length byte.
            if (step == FS_ZONE_LEN) begin
              r   = complete_entity(8'd0, 5'd0);
              hit = 1'b1;
            end else begin
              step = field_e'(step + 4'd2);
            end
          end else begin
            step = field_e'(step + 4'd1);
          end
        end
      end
      FS_OBJ_CHAR, FS_TYPE_CHAR, FS_ZONE_CHAR: begin
        idx      = chr_pos;
        k        = (step == FS_OBJ_CHAR) ? KIND_OBJECT :
                   (step == FS_TYPE_CHAR) ? KIND_TYPE : KIND_ZONE;
        chr_pos  = chr_pos + 5'd1;
        str_left = str_left - 5'd1;
        if (str_left == 0 && step == FS_ZONE_CHAR) begin
          // The final zone character is reported as the completion itself.
          r = complete_entity(b, idx + 5'd1);
        end else begin
          if (str_left == 0) step = field_e'(step + 4'd1);
          r = make_result(k, b, idx);
        end
        hit = 1'b1;
      end
      default: begin
        pkt_stop = 1'b1;
        clear_tuple();
      end
    endcase
    return hit;
  endfunction

  // Advances the model by one input transfer; returns 1 when a result is owed.
  function automatic bit nbp_parse_byte(bit cmd, logic [7:0] b, bit last, output result_t r);
    bit hit;
    hit = 1'b0;
    r   = '0;
    if (cmd) begin
      clear_packet();
      ent_cnt = '0;
      return 1'b0;
    end
    if (!pkt_stop) begin
      if (!pkt_ok) begin
        case (hdr_pos)
          HDR_PROTOCOL: begin
            if (b != cfg.expected_protocol || ent_cnt >= cfg.max_entities) pkt_stop = 1'b1;
            else hdr_pos = HDR_FUNCTION;
          end
          HDR_FUNCTION: begin
            if (b[7:4] != FuncLookupReply) begin
              pkt_stop = 1'b1;
            end else begin
              tuples_left = b[3:0];
              hdr_pos     = HDR_ID;
            end
          end
          default: begin
            if (b != cfg.expected_id) begin
              pkt_stop = 1'b1;
            end else begin
              pkt_ok  = 1'b1;
              hdr_pos = HDR_BODY;
            end
          end
        endcase
      end else begin
        hit = tuple_byte(b, r);
      end
    end
    if (last) begin
      // A packet that ends in the middle of a tuple discards it instead of any character.
      if (pkt_ok && !pkt_stop && step != FS_NET_HI) begin
        r   = make_result(KIND_DISCARD, 8'd0, 5'd0);
        hit = 1'b1;
      end
      clear_packet();
    end
    return hit;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Result checking. Every result transfer is compared with the oldest owed result.
  // ---------------------------------------------------------------------------------------
  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_monitor
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("kind: expected no result, got %0d", kind_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 16'(want.kind), 16'(kind_o));
        check_field("char_value", 16'(want.char_value), 16'(char_value_o));
        check_field("char_index", 16'(want.char_index), 16'(char_index_o));
        check_field("network", want.network, network_o);
        check_field("node", 16'(want.node), 16'(node_o));
        check_field("socket_number", 16'(want.socket_number), 16'(socket_number_o));
        check_field("entity_number", 16'(want.entity_number), 16'(entity_number_o));
        check_field("discard", 16'(want.discard), 16'(discard_o));
      end
    end
  end

  // The receiver stalls at random while its idling is enabled.
  always @(posedge clk_i) begin
    if (recv_stall > 0) recv_stall--;
    else if (recv_idle && !quiet && $urandom_range(0, 9) == 0) recv_stall = $urandom_range(1, 7);
    out_ready_i <= (recv_stall == 0);
  end

  // Watchdog: counts cycles in which no transfer of any kind takes place.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WatchLimit) begin
        $display("tb_nbp_lookup_reply_parser NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------------------

  // Sends one input transfer, with an optional idle burst before it. Returns at the clock
  // edge where it is taken, leaving valid high so the next item can follow back to back.
  task automatic send_item(input bit cmd, input logic [7:0] b, input bit last);
    int      gap;
    bit      hit;
    result_t r;
    gap = (send_idle && !quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    hit = nbp_parse_byte(cmd, b, last, r);
    if (hit) pending_results.push_back(r);
    sent_items++;
  endtask

  // Sends the assembled packet; on rare occasions a new lookup cuts into it.
  task automatic send_packet();
    for (int i = 0; i < pkt_q.size(); i++) begin
      if ($urandom_range(0, 299) == 0) send_item(1'b1, 8'($urandom), 1'b0);
      send_item(1'b0, pkt_q[i], i == pkt_q.size() - 1);
    end
    pkt_q.delete();
  endtask

  // Stops sending and lets every owed result drain before registers are touched.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle; the register takes the value at the edge that
  // closes the access cycle. The bus then idles before returning, so writes never overlap.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      RegExpectedProtocol: cfg.expected_protocol = value;
      RegExpectedId:       cfg.expected_id = value;
      RegMaxEntities:      cfg.max_entities = value;
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic void push_header(logic [3:0] count);
    pkt_q.push_back(cfg.expected_protocol);
    pkt_q.push_back({FuncLookupReply, count});
    pkt_q.push_back(cfg.expected_id);
  endfunction

  // Name lengths are mostly short, sometimes the longest legal one, rarely too long.
  function automatic int pick_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return $urandom_range(NameMax + 1, 255);
    if (roll < 8) return NameMax;
    return $urandom_range(0, 4);
  endfunction

  // Appends one tuple with random address and names. After a name that is too long the
  // tuple is left unfinished, since the parser ignores the rest anyway.
  function automatic void push_tuple();
    int len;
    repeat (5) pkt_q.push_back(8'($urandom));
    for (int s = 0; s < 3; s++) begin
      len = pick_len();
      pkt_q.push_back(8'(len));
      if (len > NameMax) break;
      repeat (len) pkt_q.push_back(8'($urandom));
    end
  endfunction

  // Builds and sends one random reply. Most are well formed; the rest carry a bad header,
  // a tuple count that disagrees with the tuples present, a cut, trailing bytes, or noise.
  task automatic send_random_reply(input int lookup_pct);
    int         pick;
    int         count;
    int         ntup;
    int         cut;
    logic [3:0] func;
    send_idle = !quiet && $urandom_range(0, 3) != 0;
    recv_idle = !quiet && $urandom_range(0, 3) != 0;
    if ($urandom_range(0, 99) < lookup_pct) send_item(1'b1, 8'($urandom), 1'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      repeat ($urandom_range(1, 6)) pkt_q.push_back(8'($urandom));
    end else begin
      count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
      func  = FuncLookupReply;
      if (pick >= 8 && pick < 12) begin
        func = 4'($urandom_range(0, 14));
        if (func >= FuncLookupReply) func = func + 4'd1;
      end
      pkt_q.push_back(pick < 8 ? cfg.expected_protocol ^ 8'($urandom_range(1, 255))
                               : cfg.expected_protocol);
      pkt_q.push_back({func, 4'(count)});
      pkt_q.push_back(pick >= 12 && pick < 16 ? cfg.expected_id ^ 8'($urandom_range(1, 255))
                                              : cfg.expected_id);
      ntup = count;
      if (pick >= 16 && pick < 24) ntup = count + 1;
      else if (pick >= 24 && pick < 30 && count > 0) ntup = count - 1;
      repeat (ntup) push_tuple();
      if (pick >= 30 && pick < 40 && pkt_q.size() > 1) begin
        cut = $urandom_range(1, pkt_q.size() - 1);
        while (pkt_q.size() > cut) void'(pkt_q.pop_back());
      end
      if (pick >= 40 && pick < 48) repeat ($urandom_range(1, 3)) pkt_q.push_back(8'($urandom));
    end
    send_packet();
  endtask

  // Sends random replies until enough input transfers were sent or the packet budget is
  // used up.
  task automatic run_replies(input int item_goal, input int packet_cap, input int lookup_pct);
    int start;
    int sent;
    start = sent_items;
    sent  = 0;
    while (sent_items - start < item_goal && sent < packet_cap) begin
      send_random_reply(lookup_pct);
      sent++;
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------------------

  // A new lookup gives no result and ignores its data fields.
  task automatic test_new_lookup();
    send_item(1'b1, 8'hA5, 1'b1);
  endtask

  // One entity with all names empty under the reset registers, address at its extremes.
  // The empty zone length completes the entity; the packet then ends between tuples.
  task automatic test_empty_entity();
    push_header(4'd1);
    pkt_q.push_back(8'hFF);
    pkt_q.push_back(8'hFF);
    pkt_q.push_back(8'h00);
    pkt_q.push_back(8'hFF);
    pkt_q.push_back(8'h80);
    repeat (3) pkt_q.push_back(8'h00);
    send_packet();
  endtask

  // A wrong protocol byte that also ends the packet is ignored.
  task automatic test_header_reject();
    send_item(1'b0, cfg.expected_protocol ^ 8'h01, 1'b1);
  endtask

  // An object length one above the limit discards the entity and stops the packet.
  task automatic test_name_too_long();
    push_header(4'd2);
    pkt_q.push_back(8'h12);
    pkt_q.push_back(8'h34);
    pkt_q.push_back(8'h56);
    pkt_q.push_back(8'h78);
    pkt_q.push_back(8'h00);
    pkt_q.push_back(8'(NameMax + 1));
    send_packet();
  endtask

  // A packet that ends right after the first network byte discards the tuple.
  task automatic test_packet_ends_in_tuple();
    push_header(4'd1);
    pkt_q.push_back(8'h7F);
    send_packet();
  endtask

  task automatic test_random_replies();
    wait_idle();
    write_reg(RegExpectedProtocol, 8'($urandom));
    write_reg(RegExpectedId, 8'($urandom));
    write_reg(RegMaxEntities, 8'd255);
    send_item(1'b1, 8'($urandom), 1'b0);
    run_replies(400, 100000, 3);
  endtask

  // Small entity limits, with new lookups common so the limit is hit again and again.
  task automatic test_entity_limit();
    logic [7:0] limits[5];
    limits = '{8'd0, 8'd1, 8'd2, 8'd3, 8'($urandom_range(4, 8))};
    foreach (limits[i]) begin
      wait_idle();
      write_reg(RegMaxEntities, limits[i]);
      run_replies(60, 25, 30);
    end
  endtask

  task automatic test_register_extremes();
    wait_idle();
    write_reg(RegExpectedProtocol, 8'hFF);
    write_reg(RegExpectedId, 8'hFF);
    write_reg(RegMaxEntities, 8'hFF);
    send_item(1'b1, 8'h00, 1'b0);
    run_replies(120, 100000, 3);
    wait_idle();
    write_reg(RegExpectedProtocol, 8'h00);
    write_reg(RegExpectedId, 8'h00);
    run_replies(120, 100000, 3);
  endtask

  // Last part: no idling on either side; bytes move every cycle, results leave once made.
  task automatic test_steady_stream();
    wait_idle();
    quiet = 1'b1;
    write_reg(RegExpectedProtocol, 8'($urandom));
    write_reg(RegExpectedId, 8'($urandom));
    run_replies(200, 100000, 3);
  endtask

  initial begin
    // Every input is known from time zero; the model starts at its reset state.
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    command_i   = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    out_ready_i = 1'b0;
    fail_count   = 0;
    sent_items   = 0;
    recv_stall   = 0;
    stuck_cycles = 0;
    quiet        = 1'b0;
    send_idle    = 1'b1;
    recv_idle    = 1'b1;
    cfg     = '{ExpectedProtocolReset, ExpectedIdReset, MaxEntitiesReset};
    ent_cnt = '0;
    clear_packet();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_new_lookup();
    test_empty_entity();
    test_header_reject();
    test_name_too_long();
    test_packet_ends_in_tuple();
    test_random_replies();
    test_entity_limit();
    test_register_extremes();
    test_steady_stream();

    // Drain: wait a bounded time for the last results, then keep watching for strays.
    in_valid_i <= 1'b0;
    for (int c = 0; c < 200 && pending_results.size() != 0; c++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("kind: expected %0d more results, got none", pending_results.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("tb_nbp_lookup_reply_parser OK");
    end else begin
      $display("tb_nbp_lookup_reply_parser NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/nlrp_pkg.sv
rtl/nlrp_parser.sv
rtl/nlrp_fifo.sv
rtl/nbp_lookup_reply_parser.sv
tb/sv/tb_nbp_lookup_reply_parser.sv
